@@ design/mfad_pkg.sv @@
`default_nettype none
package mfad_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hF1;
    localparam logic [7:0] HDR_SECOND = 8'hDD;
    localparam logic [7:0] AT_START   = 8'h2B;
    localparam logic [7:0] AT_END     = 8'h0A;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_GOT_F1 = 4'd1,
        PH_NET    = 4'd2,
        PH_SRC_HI = 4'd3,
        PH_SRC_LO = 4'd4,
        PH_DST_HI = 4'd5,
        PH_DST_LO = 4'd6,
        PH_KEY    = 4'd7,
        PH_LEFT   = 4'd8,
        PH_RIGHT  = 4'd9,
        PH_TRL_HI = 4'd10,
        PH_TRL_LO = 4'd11,
        PH_LINE   = 4'd12
    } t_phase;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_LINE   = 1'b1;

    typedef struct packed {
        logic [7:0]  net_hold;
        logic [15:0] src_hold;
        logic [15:0] dst_hold;
        logic [7:0]  key_hold;
        logic [7:0]  left_hold;
        logic [7:0]  right_hold;
        logic [7:0]  trailer_high;
    } t_hold;

    typedef struct packed {
        logic        kind;
        logic [7:0]  net_id;
        logic [15:0] src_addr;
        logic [15:0] dst_addr;
        logic [7:0]  key_value;
        logic [7:0]  left_value;
        logic [7:0]  right_value;
        logic [15:0] trailer;
        logic [7:0]  line_byte;
        logic        line_last;
    } t_result;

endpackage
`default_nettype wire

@@ design/mfad_in_if.sv @@
`default_nettype none
interface mfad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ design/mfad_out_if.sv @@
`default_nettype none
interface mfad_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  net_id;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [7:0]  key_value;
    logic [7:0]  left_value;
    logic [7:0]  right_value;
    logic [15:0] trailer;
    logic [7:0]  line_byte;
    logic        line_last;

    modport source (
        output valid, output kind, output net_id, output src_addr, output dst_addr,
        output key_value, output left_value, output right_value, output trailer,
        output line_byte, output line_last, input ready
    );
    modport sink (
        input valid, input kind, input net_id, input src_addr, input dst_addr,
        input key_value, input left_value, input right_value, input trailer,
        input line_byte, input line_last, output ready
    );
endinterface
`default_nettype wire

@@ design/mesh_frame_and_at_line_deframer_unit.sv @@
`default_nettype none
// path: a result's last byte goes from the input register through the parser
// into the result register; throughput: one byte per cycle while the output
// is not stalled, set by the single parser stage between the two registers
// reset: synchronous active-low i_rst_n returns to header hunt, clears the
// captured fields and empties both registers
module mesh_frame_and_at_line_deframer_unit
    import mfad_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    mfad_in_if.sink    i_in,
    mfad_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_phase     r_phase;
    t_hold      r_hold;
    logic       r_out_valid;
    t_result    r_out;

    t_phase     n_phase;
    t_hold      n_hold;
    logic       emit;
    t_result    result;
    logic       advance;

    mfad_parser u_parser (
        .i_phase  (r_phase),
        .i_hold   (r_hold),
        .i_byte   (r_in_byte),
        .o_phase  (n_phase),
        .o_hold   (n_hold),
        .o_emit   (emit),
        .o_result (result)
    );

    // the held byte moves on once the result register can take its result
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_hold  <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.net_id      = r_out.net_id;
    assign o_out.src_addr    = r_out.src_addr;
    assign o_out.dst_addr    = r_out.dst_addr;
    assign o_out.key_value   = r_out.key_value;
    assign o_out.left_value  = r_out.left_value;
    assign o_out.right_value = r_out.right_value;
    assign o_out.trailer     = r_out.trailer;
    assign o_out.line_byte   = r_out.line_byte;
    assign o_out.line_last   = r_out.line_last;

endmodule
`default_nettype wire

@@ design/mfad_parser.sv @@
`default_nettype none
module mfad_parser
    import mfad_pkg::*;
(
    input  wire t_phase   i_phase,
    input  wire t_hold    i_hold,
    input  wire [7:0]     i_byte,
    output t_phase        o_phase,
    output t_hold         o_hold,
    output logic          o_emit,
    output t_result       o_result
);

    t_phase  hunt_phase;
    logic    hunt_emit;
    t_result line_res;
    t_result pkt_res;

    // byte seen while hunting or re-examined after a broken header
    always_comb begin
        if (i_byte == HDR_FIRST) begin
            hunt_phase = PH_GOT_F1;
            hunt_emit  = 1'b0;
        end else if (i_byte == AT_START) begin
            hunt_phase = PH_LINE;
            hunt_emit  = 1'b1;
        end else begin
            hunt_phase = PH_HUNT;
            hunt_emit  = 1'b0;
        end
    end

    always_comb begin
        line_res           = '0;
        line_res.kind      = KIND_LINE;
        line_res.line_byte = i_byte;
        line_res.line_last = (i_byte == AT_END);

        pkt_res             = '0;
        pkt_res.kind        = KIND_PACKET;
        pkt_res.net_id      = i_hold.net_hold;
        pkt_res.src_addr    = i_hold.src_hold;
        pkt_res.dst_addr    = i_hold.dst_hold;
        pkt_res.key_value   = i_hold.key_hold;
        pkt_res.left_value  = i_hold.left_hold;
        pkt_res.right_value = i_hold.right_hold;
        pkt_res.trailer     = {i_hold.trailer_high, i_byte};
    end

    always_comb begin
        o_phase  = i_phase;
        o_hold   = i_hold;
        o_emit   = 1'b0;
        o_result = line_res;
        case (i_phase)
            PH_GOT_F1: begin
                if (i_byte == HDR_SECOND) begin
                    o_phase = PH_NET;
                end else begin
                    o_phase = hunt_phase;
                    o_emit  = hunt_emit;
                end
            end
            PH_NET: begin
                o_hold.net_hold = i_byte;
                o_phase         = PH_SRC_HI;
            end
            PH_SRC_HI: begin
                o_hold.src_hold = {i_hold.src_hold[7:0], i_byte};
                o_phase         = PH_SRC_LO;
            end
            PH_SRC_LO: begin
                o_hold.src_hold = {i_hold.src_hold[7:0], i_byte};
                o_phase         = PH_DST_HI;
            end
            PH_DST_HI: begin
                o_hold.dst_hold = {i_hold.dst_hold[7:0], i_byte};
                o_phase         = PH_DST_LO;
            end
            PH_DST_LO: begin
                o_hold.dst_hold = {i_hold.dst_hold[7:0], i_byte};
                o_phase         = PH_KEY;
            end
            PH_KEY: begin
                o_hold.key_hold = i_byte;
                o_phase         = PH_LEFT;
            end
            PH_LEFT: begin
                o_hold.left_hold = i_byte;
                o_phase          = PH_RIGHT;
            end
            PH_RIGHT: begin
                o_hold.right_hold = i_byte;
                o_phase           = PH_TRL_HI;
            end
            PH_TRL_HI: begin
                o_hold.trailer_high = i_byte;
                o_phase             = PH_TRL_LO;
            end
            PH_TRL_LO: begin
                o_result = pkt_res;
                o_emit   = 1'b1;
                o_phase  = PH_HUNT;
            end
            PH_LINE: begin
                o_emit = 1'b1;
                if (i_byte == AT_END) begin
                    o_phase = PH_HUNT;
                end
            end
            default: begin
                o_phase = hunt_phase;
                o_emit  = hunt_emit;
            end
        endcase
    end

endmodule
`default_nettype wire
